[rtl/ktn_pkg.sv]
// Shared types, constants and codes of the keyed top-N score table.
package ktn_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int KEY_W             = 32;
    localparam int SCORE_W           = 32;
    localparam int RANK_W            = 3;
    localparam int OUTCOME_W         = 2;

    localparam logic [KEY_W-1:0] EMPTY_KEY_RESET = 32'hFFFF_FFFF;

    localparam logic OP_SUBMIT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_READ     = 2'd3;

    typedef struct packed {
        logic load;
        logic rd_issue;
        logic rd_capture;
        logic scan_issue;
        logic decide;
        logic sh_issue;
        logic place;
        logic emit;
    } ktn_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic reject;
        logic move;
        logic sh_last;
        logic out_free;
    } ktn_sts_t;

endpackage

[rtl/ktn_if.sv]
// Channel interfaces: request items, result items and the configuration write.
interface ktn_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [ktn_pkg::KEY_W-1:0]   entry_key;
    logic [ktn_pkg::SCORE_W-1:0] score;
    logic [ktn_pkg::RANK_W-1:0]  read_rank;

    modport source (output valid, operation, entry_key, score, read_rank, input ready);
    modport sink   (input valid, operation, entry_key, score, read_rank, output ready);
endinterface

interface ktn_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ktn_pkg::OUTCOME_W-1:0] outcome;
    logic [ktn_pkg::RANK_W-1:0]    new_rank;
    logic [ktn_pkg::KEY_W-1:0]     read_key;
    logic [ktn_pkg::SCORE_W-1:0]   read_score;

    modport source (output valid, outcome, new_rank, read_key, read_score, input ready);
    modport sink   (input valid, outcome, new_rank, read_key, read_score, output ready);
endinterface

interface ktn_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ktn_pkg::KEY_W-1:0] empty_key;

    modport source (output valid, empty_key, input ready);
    modport sink   (input valid, empty_key, output ready);
endinterface

[rtl/keyed_top_n_score_table_unit.sv]
// Top level of the keyed top-N score table.
//
//  channel | dir | handshake       | contents
//  req     | in  | valid / ready   | operation, entry_key, score, read_rank
//  rsp     | out | valid / ready   | outcome, new_rank, read_key, read_score
//  cfg     | in  | valid / ready   | empty_key
//
// One item at a time. A read issues the RAM read, captures the entry and emits it.
// A submit scans all entries and decides: a reject goes to emit, a kept rank is placed,
// and a move of d ranks shifts the d entries in between, then places; the scan reads
// one entry per cycle and the shift moves one entry per cycle through the RAM ports.
// A result waits in the output register; a stalled rsp holds the next result back.
// Reset clears the entry valid bits at once; no clearing pass is needed.
module keyed_top_n_score_table_unit #(
    parameter int TABLE_ENTRIES = ktn_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ktn_req_if.sink     req,
    ktn_rsp_if.source   rsp,
    ktn_cfg_if.sink     cfg
);

    ktn_pkg::ktn_cmd_t cmd;
    ktn_pkg::ktn_sts_t sts;

    // empty-key marker written through cfg; the datapath does not read it
    logic [ktn_pkg::KEY_W-1:0] empty_key_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_key_reg <= ktn_pkg::EMPTY_KEY_RESET;
        end
        else if (cfg.valid)
        begin
            empty_key_reg <= cfg.empty_key;
        end
    end

    ktn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ktn_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_operation  (req.operation),
        .req_entry_key  (req.entry_key),
        .req_score      (req.score),
        .req_read_rank  (req.read_rank),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_outcome    (rsp.outcome),
        .rsp_new_rank   (rsp.new_rank),
        .rsp_read_key   (rsp.read_key),
        .rsp_read_score (rsp.read_score)
    );

endmodule

[rtl/ktn_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
module ktn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = ktn_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ktn_ctrl.sv]
// Sequencer of the score table: read, scan, decide, shift, place and emit phases.
module ktn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_operation,
    output logic              req_ready,
    input  ktn_pkg::ktn_sts_t sts,
    output ktn_pkg::ktn_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD_ISSUE  = 4'd1;
    localparam logic [3:0] S_RD_DATA   = 4'd2;
    localparam logic [3:0] S_SCAN      = 4'd3;
    localparam logic [3:0] S_SCAN_END  = 4'd4;
    localparam logic [3:0] S_DECIDE    = 4'd5;
    localparam logic [3:0] S_SHIFT     = 4'd6;
    localparam logic [3:0] S_SHIFT_END = 4'd7;
    localparam logic [3:0] S_PLACE     = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_operation == ktn_pkg::OP_READ) ? S_RD_ISSUE : S_SCAN;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_EMIT;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                // last entry of the scan is judged in this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                priority if (sts.reject)
                begin
                    state_next = S_EMIT;
                end
                else if (sts.move)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SHIFT:
            begin
                cmd.sh_issue = 1'b1;
                if (sts.sh_last)
                begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END:
            begin
                // drain the last shifted entry
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg != S_IDLE)
        else $error("ktn_ctrl: still idle after taking an item");
`endif

endmodule

[rtl/ktn_dp.sv]
// Datapath of the score table: entry RAM, valid bits, scan counters, shift pointer, result stage.
module ktn_dp #(
    parameter int TABLE_ENTRIES = ktn_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ktn_pkg::ktn_cmd_t               cmd,
    output ktn_pkg::ktn_sts_t               sts,
    input  logic                            req_operation,
    input  logic [ktn_pkg::KEY_W-1:0]       req_entry_key,
    input  logic [ktn_pkg::SCORE_W-1:0]     req_score,
    input  logic [ktn_pkg::RANK_W-1:0]      req_read_rank,
    input  logic                            rsp_ready,
    output logic                            rsp_valid,
    output logic [ktn_pkg::OUTCOME_W-1:0]   rsp_outcome,
    output logic [ktn_pkg::RANK_W-1:0]      rsp_new_rank,
    output logic [ktn_pkg::KEY_W-1:0]       rsp_read_key,
    output logic [ktn_pkg::SCORE_W-1:0]     rsp_read_score
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int XW = AW + ktn_pkg::RANK_W;
    localparam int EW = ktn_pkg::KEY_W + ktn_pkg::SCORE_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    // item fields
    logic                            op_reg;
    logic [ktn_pkg::KEY_W-1:0]       key_reg;
    logic [ktn_pkg::SCORE_W-1:0]     score_reg;
    logic [ktn_pkg::RANK_W-1:0]      rank_reg;

    // scan and shift
    logic [AW-1:0]                   scan_idx_reg;
    logic                            pipe_scan_reg;
    logic                            pipe_shift_reg;
    logic [AW-1:0]                   pipe_idx_reg;
    logic                            rd_vld_reg;
    logic                            found_reg;
    logic [AW-1:0]                   match_idx_reg;
    logic [AW-1:0]                   ge_reg;
    logic [AW-1:0]                   gt_reg;
    logic [ktn_pkg::SCORE_W-1:0]     last_score_reg;
    logic [AW-1:0]                   tgt_reg;
    logic [AW-1:0]                   sh_ptr_reg;
    logic                            dir_up_reg;
    logic [TABLE_ENTRIES-1:0]        valid_reg;

    // result hold and output stage
    logic [ktn_pkg::OUTCOME_W-1:0]   res_outcome_reg;
    logic [ktn_pkg::RANK_W-1:0]      res_rank_reg;
    logic [ktn_pkg::KEY_W-1:0]       res_key_reg;
    logic [ktn_pkg::SCORE_W-1:0]     res_score_reg;
    logic                            out_valid_reg;
    logic [ktn_pkg::OUTCOME_W-1:0]   out_outcome_reg;
    logic [ktn_pkg::RANK_W-1:0]      out_rank_reg;
    logic [ktn_pkg::KEY_W-1:0]       out_key_reg;
    logic [ktn_pkg::SCORE_W-1:0]     out_score_reg;

    // RAM ports
    logic                            we;
    logic [AW-1:0]                   waddr;
    logic [EW-1:0]                   wdata;
    logic                            re;
    logic [AW-1:0]                   raddr;
    logic [EW-1:0]                   rdata;

    logic                            rank_ok;
    logic [ktn_pkg::KEY_W-1:0]       ent_key;
    logic [ktn_pkg::SCORE_W-1:0]     ent_score;
    logic                            beats_last;
    logic [AW-1:0]                   src_next;
    logic [AW-1:0]                   tgt_next;
    logic                            up_next;
    logic [XW-1:0]                   tgt_ext;
    logic [ktn_pkg::RANK_W-1:0]      rank_sat;
    logic [ktn_pkg::OUTCOME_W-1:0]   outcome_next;

    ktn_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rank_ok = XW'(rank_reg) < XW'(TABLE_ENTRIES);

    // an entry never written since reset reads as EMPTY_KEY_RESET with score zero
    assign ent_key   = rd_vld_reg ? rdata[EW-1:ktn_pkg::SCORE_W] : ktn_pkg::EMPTY_KEY_RESET;
    assign ent_score = rd_vld_reg ? rdata[ktn_pkg::SCORE_W-1:0]  : '0;

    always_comb
    begin
        re    = 1'b0;
        raddr = scan_idx_reg;
        priority if (cmd.rd_issue)
        begin
            re    = rank_ok;
            raddr = AW'(rank_reg);
        end
        else if (cmd.scan_issue)
        begin
            re    = 1'b1;
            raddr = scan_idx_reg;
        end
        else if (cmd.sh_issue)
        begin
            re    = 1'b1;
            raddr = sh_ptr_reg;
        end
        else
        begin
            re = 1'b0;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_reg;
        wdata = {key_reg, score_reg};
        priority if (pipe_shift_reg)
        begin
            we    = 1'b1;
            waddr = dir_up_reg ? (pipe_idx_reg + AW'(1)) : (pipe_idx_reg - AW'(1));
            wdata = {ent_key, ent_score};
        end
        else if (cmd.place)
        begin
            we = 1'b1;
        end
        else
        begin
            we = 1'b0;
        end
    end

    // final rank: entries above the new score, plus equal ones that stood before it
    assign beats_last = score_reg > last_score_reg;
    assign src_next   = found_reg ? match_idx_reg : LAST_IDX;
    assign tgt_next   = ge_reg + gt_reg;
    assign up_next    = tgt_next < src_next;
    assign tgt_ext    = XW'(tgt_next);
    assign rank_sat   = (tgt_ext > XW'(7)) ? ktn_pkg::RANK_W'(7) : tgt_ext[ktn_pkg::RANK_W-1:0];

    always_comb
    begin
        priority if (found_reg)
        begin
            outcome_next = ktn_pkg::OUT_UPDATED;
        end
        else if (beats_last)
        begin
            outcome_next = ktn_pkg::OUT_INSERTED;
        end
        else
        begin
            outcome_next = ktn_pkg::OUT_REJECTED;
        end
    end

    assign sts.scan_last = scan_idx_reg == LAST_IDX;
    assign sts.reject    = !found_reg && !beats_last;
    assign sts.move      = tgt_next != src_next;
    assign sts.sh_last   = sh_ptr_reg == tgt_reg;
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_scan_reg  <= 1'b0;
            pipe_shift_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pipe_scan_reg  <= cmd.scan_issue;
            pipe_shift_reg <= cmd.sh_issue;
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= req_operation;
            key_reg       <= req_entry_key;
            score_reg     <= req_score;
            rank_reg      <= req_read_rank;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            ge_reg        <= '0;
            gt_reg        <= '0;
            res_rank_reg  <= '0;
            res_key_reg   <= '0;
            res_score_reg <= '0;
        end

        if (cmd.scan_issue)
        begin
            scan_idx_reg <= scan_idx_reg + AW'(1);
        end

        if (re)
        begin
            pipe_idx_reg <= raddr;
            rd_vld_reg   <= valid_reg[raddr];
        end

        // judge one scanned entry per cycle
        if (pipe_scan_reg)
        begin
            if ((ent_key == key_reg) && !found_reg)
            begin
                found_reg     <= 1'b1;
                match_idx_reg <= pipe_idx_reg;
            end
            else if (found_reg)
            begin
                if (ent_score > score_reg)
                begin
                    gt_reg <= gt_reg + AW'(1);
                end
            end
            else if (pipe_idx_reg != LAST_IDX)
            begin
                if (ent_score >= score_reg)
                begin
                    ge_reg <= ge_reg + AW'(1);
                end
            end
            if (pipe_idx_reg == LAST_IDX)
            begin
                last_score_reg <= ent_score;
            end
        end

        if (cmd.decide)
        begin
            tgt_reg         <= tgt_next;
            dir_up_reg      <= up_next;
            sh_ptr_reg      <= up_next ? (src_next - AW'(1)) : (src_next + AW'(1));
            res_outcome_reg <= outcome_next;
            res_rank_reg    <= sts.reject ? '0 : rank_sat;
        end

        if (cmd.sh_issue)
        begin
            sh_ptr_reg <= dir_up_reg ? (sh_ptr_reg - AW'(1)) : (sh_ptr_reg + AW'(1));
        end

        if (cmd.rd_capture)
        begin
            res_outcome_reg <= ktn_pkg::OUT_READ;
            res_rank_reg    <= '0;
            res_key_reg     <= (rank_ok && op_reg == ktn_pkg::OP_READ) ? ent_key : '0;
            res_score_reg   <= (rank_ok && op_reg == ktn_pkg::OP_READ) ? ent_score : '0;
        end

        if (cmd.emit)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_rank_reg    <= res_rank_reg;
            out_key_reg     <= res_key_reg;
            out_score_reg   <= res_score_reg;
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_outcome    = out_outcome_reg;
    assign rsp_new_rank   = out_rank_reg;
    assign rsp_read_key   = out_key_reg;
    assign rsp_read_score = out_score_reg;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (we && re) |-> (waddr != raddr))
        else $error("ktn_dp: read and write at the same entry");

    a_rank_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> ((AW + 1)'(ge_reg) + (AW + 1)'(gt_reg)) <= (AW + 1)'(TABLE_ENTRIES - 1))
        else $error("ktn_dp: final rank beyond the table");

    a_place_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !pipe_shift_reg)
        else $error("ktn_dp: placement collides with a shift write");

    a_submit_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_outcome_reg != ktn_pkg::OUT_READ)
            |-> (out_key_reg == '0 && out_score_reg == '0))
        else $error("ktn_dp: submit result carries entry data");
`endif

endmodule

[dv/ktn_table_board_pkg.sv]
// Scoreboard for the keyed top-N score table: table tracker and result queue.
package ktn_table_board_pkg;

    import ktn_pkg::*;

    localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [RANK_W-1:0]    new_rank;
        logic [KEY_W-1:0]     read_key;
        logic [SCORE_W-1:0]   read_score;
    } table_reply_t;

    class ranked_table_board;

        logic [KEY_W-1:0]   marker;
        logic [KEY_W-1:0]   keys [TABLE_DEPTH];
        logic [SCORE_W-1:0] scores [TABLE_DEPTH];
        table_reply_t       pending_replies [$];
        int                 mismatches;

        function new();
            marker = EMPTY_KEY_RESET;
            mismatches = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                keys[i] = marker;
                scores[i] = '0;
            end
        endfunction

        // The marker only seeds the table at reset; a later write leaves entries alone.
        function void set_marker(logic [KEY_W-1:0] value);
            marker = value;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Stable descending insertion sort; follow one slot to its final rank.
        function int settle_ranks(int watch);
            int                 j;
            logic [KEY_W-1:0]   k;
            logic [SCORE_W-1:0] s;
            for (int i = 1; i < TABLE_DEPTH; i++)
            begin
                j = i;
                while (j > 0 && scores[j-1] < scores[j])
                begin
                    k = keys[j];
                    s = scores[j];
                    keys[j] = keys[j-1];
                    scores[j] = scores[j-1];
                    keys[j-1] = k;
                    scores[j-1] = s;
                    if (watch == j)
                        watch = j - 1;
                    else if (watch == j - 1)
                        watch = j;
                    j--;
                end
            end
            return watch;
        endfunction

        function void note_item(logic op, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] sc,
                                logic [RANK_W-1:0] rank);
            table_reply_t r;
            int           slot;
            bit           hit;
            r = '0;
            slot = 0;
            hit = 1'b0;
            if (op == OP_READ)
            begin
                r.outcome = OUT_READ;
                if (int'(rank) < TABLE_DEPTH)
                begin
                    r.read_key = keys[rank];
                    r.read_score = scores[rank];
                end
            end
            else
            begin
                for (int i = 0; i < TABLE_DEPTH && !hit; i++)
                begin
                    if (keys[i] == key)
                    begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                if (hit)
                begin
                    scores[slot] = sc;
                    slot = settle_ranks(slot);
                    r.outcome = OUT_UPDATED;
                end
                else if (sc > scores[TABLE_DEPTH-1])
                begin
                    keys[TABLE_DEPTH-1] = key;
                    scores[TABLE_DEPTH-1] = sc;
                    slot = settle_ranks(TABLE_DEPTH - 1);
                    r.outcome = OUT_INSERTED;
                end
                else
                begin
                    r.outcome = OUT_REJECTED;
                    slot = 0;
                end
                // saturate ranks that do not fit the field
                r.new_rank = (slot > 7) ? 3'd7 : slot[RANK_W-1:0];
            end
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(logic [OUTCOME_W-1:0] outcome, logic [RANK_W-1:0] new_rank,
                                  logic [KEY_W-1:0] read_key, logic [SCORE_W-1:0] read_score);
            table_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("result with no item outstanding: outcome %0d", outcome);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("outcome", 64'(want.outcome), 64'(outcome));
            compare_field("new_rank", 64'(want.new_rank), 64'(new_rank));
            compare_field("read_key", 64'(want.read_key), 64'(read_key));
            compare_field("read_score", 64'(want.read_score), 64'(read_score));
        endfunction

    endclass

endpackage

[dv/tb_keyed_top_n_score_table_unit.sv]
// Testbench top for the keyed top-N score table unit.
module tb_keyed_top_n_score_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import ktn_pkg::*;
    import ktn_table_board_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int FIRST_HOLD  = 700;
    localparam int SECOND_HOLD = 1500;
    localparam int SETTLE_WAIT = 40;
    localparam int POOL_SIZE   = 12;

    logic clk = 1'b0;
    logic rst_n;
    int   items_sent = 0;
    int   cycle_count = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    ranked_table_board board;

    ktn_req_if req_ch ();
    ktn_rsp_if rsp_ch ();
    ktn_cfg_if cfg_ch ();

    keyed_top_n_score_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_reply(rsp_ch.outcome, rsp_ch.new_rank, rsp_ch.read_key,
                              rsp_ch.read_score);
    end

    // Result side: switch between stall patterns, plus two long hold-offs.
    initial
    begin
        int mode;
        int left;
        int holds_done;
        rsp_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < 2 && items_sent >= (holds_done == 0 ? FIRST_HOLD : SECOND_HOLD))
            begin
                rsp_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(40, 250);
            end
            left--;
            case (mode)
                0:       rsp_ch.ready = 1'b1;
                1:       rsp_ch.ready = 1'($urandom_range(0, 1));
                default: rsp_ch.ready = (left % 7) < 4;
            endcase
        end
    end

    // Called at a falling edge; leaves valid high for a back-to-back item.
    task automatic send_item(logic op, logic [KEY_W-1:0] key, logic [SCORE_W-1:0] sc,
                             logic [RANK_W-1:0] rank);
        req_ch.operation = op;
        req_ch.entry_key = key;
        req_ch.score = sc;
        req_ch.read_rank = rank;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_item(op, key, sc, rank);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender(int cycles);
        req_ch.valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_marker(logic [KEY_W-1:0] value);
        cfg_ch.empty_key = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_marker(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic run_random(int count);
        int                 burst;
        logic               op;
        logic               fresh;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] sc;
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0)
            begin
                op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_SUBMIT;
                fresh = ($urandom_range(0, 6) == 0);
                key = fresh ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (fresh)
                    // keep unknown keys mostly low so the table keeps turning over
                    sc = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20);
                else
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: sc = $urandom_range(0, 15);
                        4, 5:       sc = $urandom;
                        6:          sc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                        7:          sc = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                        default:    sc = $urandom_range(0, 3);
                    endcase
                send_item(op, key, sc, RANK_W'($urandom_range(0, 7)));
                burst--;
                count--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 10));
        end
        wait_drained();
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_SUBMIT;
        req_ch.entry_key = '0;
        req_ch.score = '0;
        req_ch.read_rank = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.empty_key = '0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_marker(32'h0);

        // Directed: empty table reads, marker key match, ties, fill, moves both ways.
        send_item(OP_READ, 32'h0, 32'h0, 3'd0);
        send_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        send_item(OP_SUBMIT, 32'hFFFF_FFFF, 32'd5, 3'd0);
        send_item(OP_SUBMIT, 32'h0, 32'h0, 3'd0);
        send_item(OP_SUBMIT, 32'h0, 32'd1, 3'd0);
        send_item(OP_SUBMIT, 32'h8000_0001, 32'hFFFF_FFFF, 3'd0);
        send_item(OP_SUBMIT, 32'd1, 32'd1, 3'd0);
        send_item(OP_SUBMIT, 32'd2, 32'hFFFF_FFFF, 3'd0);
        send_item(OP_SUBMIT, 32'd3, 32'd100, 3'd0);
        send_item(OP_SUBMIT, 32'd4, 32'd200, 3'd0);
        send_item(OP_SUBMIT, 32'd5, 32'd300, 3'd0);
        send_item(OP_SUBMIT, 32'd6, 32'd400, 3'd0);
        send_item(OP_SUBMIT, 32'd7, 32'd2, 3'd0);
        send_item(OP_SUBMIT, 32'h0, 32'h0, 3'd0);
        send_item(OP_SUBMIT, 32'd5, 32'h0, 3'd0);
        send_item(OP_SUBMIT, 32'd1, 32'hFFFF_FFFE, 3'd0);
        send_item(OP_SUBMIT, 32'h7FFF_FFFF, 32'h0, 3'd0);
        for (int r = 0; r < 8; r++)
            send_item(OP_READ, $urandom, $urandom, r[RANK_W-1:0]);
        wait_drained();

        write_marker($urandom);
        run_random(600);
        write_marker(32'hFFFF_FFFF);
        run_random(600);
        write_marker($urandom);
        run_random(600);

        repeat (SETTLE_WAIT) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[keyed_top_n_score_table_unit.f]
rtl/ktn_pkg.sv
rtl/ktn_if.sv
rtl/ktn_ram.sv
rtl/ktn_ctrl.sv
rtl/ktn_dp.sv
rtl/keyed_top_n_score_table_unit.sv
dv/ktn_table_board_pkg.sv
dv/tb_keyed_top_n_score_table_unit.sv
